// ----- rtl/core/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern scanner.
// Used by every module in rtl/core; no dependencies of its own.
`default_nettype none

package mbps_pkg;

  // Size of the pattern register file and of the scan window
  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned REG_BYTES   = 32;
  localparam int unsigned LEN_CAP     = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
  localparam int unsigned OFFSET_BITS = 32;

  // Field widths
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned FILL_W   = $clog2(LEN_CAP + 1);
  localparam int unsigned IDX_W    = $clog2(REG_BYTES);
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MOFF_W   = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO     = 3'd0,
    CFG_PAT_MID_LO = 3'd1,
    CFG_PAT_MID_HI = 3'd2,
    CFG_PAT_HI     = 3'd3,
    CFG_CARE_MASK  = 3'd4,
    CFG_PAT_LEN    = 3'd5,
    CFG_REPORT_ALL = 3'd6
  } cfg_idx_e;

  // Window as seen by the compare: entry 0 is the newest byte
  typedef logic [7:0] win_t [LEN_CAP];

  // One result item
  typedef struct packed {
    logic [MOFF_W-1:0] match_offset;
    logic              matched;
    logic              region_done;
    logic              any_found;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbps_match.sv -----
// Parallel masked compare of the scan window against the configured pattern.
// Depends on mbps_pkg.
`default_nettype none

module mbps_match (
  input  mbps_pkg::win_t                         win_i,
  input  logic [mbps_pkg::REG_BYTES*8-1:0]       pattern_i,
  input  logic [mbps_pkg::REG_BYTES-1:0]         care_mask_i,
  input  logic [mbps_pkg::LEN_W-1:0]             len_i,
  output logic                                   hit_o
);
  import mbps_pkg::*;

  logic [LEN_W-1:0] pos  [LEN_CAP];
  logic [LEN_CAP-1:0] miss;

  // Window entry j (age j) lines up with pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < int'(LEN_CAP); j++) begin
      pos[j]  = len_i - LEN_W'(j) - LEN_W'(1);
      miss[j] = (LEN_W'(j) < len_i)
              && care_mask_i[pos[j][IDX_W-1:0]]
              && (pattern_i[pos[j][IDX_W-1:0]*8 +: 8] != win_i[j]);
    end
  end

  assign hit_o = ~|miss;

endmodule

`default_nettype wire

// ----- rtl/core/mbps_skid.sv -----
// Output register plus one skid entry for the result channel.
// Depends on mbps_pkg.
`default_nettype none

module mbps_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbps_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mbps_pkg::result_t out_o
);
  import mbps_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  // Refill the output register from the skid first, then from a new result
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/masked_byte_pattern_scanner_top.sv -----
// Top level of the masked byte pattern scanner: config registers, window, result logic.
// Depends on mbps_pkg, mbps_match and mbps_skid.
//
// Takes one byte per clock unless stalled and puts its result (a match offset, a
// region-done flag, or both) in the output register, or the skid entry under a stall;
// bytes that neither complete a reported match nor end a region give no result. All
// window positions compare in parallel, so the sustained rate is one byte per cycle
// unless stalled. The result side has an output register and one skid entry;
// in_stall_o rises only when both hold a result the consumer has not yet taken.
// Configuration writes are meant for idle periods and take effect on the next byte.
`default_nettype none

module masked_byte_pattern_scanner_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mbps_pkg::CFG_W-1:0]         cfg_wdata_i,
  // byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               region_end_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mbps_pkg::MOFF_W-1:0]        match_offset_o,
  output logic                               matched_o,
  output logic                               region_done_o,
  output logic                               any_found_o
);
  import mbps_pkg::*;

  localparam int unsigned CMP_W = (FILL_W > LEN_W) ? FILL_W + 1 : LEN_W + 1;

  // Configuration registers
  logic [REG_BYTES*8-1:0] pat_q;
  logic [REG_BYTES-1:0]   care_q;
  logic [LEN_W-1:0]       plen_q;
  logic                   rall_q;

  // Scan state
  logic [7:0]             win_q [LEN_CAP-1];
  logic [FILL_W-1:0]      fill_q, fill_d, fill_inc;
  logic [OFFSET_BITS-1:0] off_q, off_d, start;
  logic                   found_q, found_d;

  logic                   accept;
  logic [LEN_W-1:0]       len_eff;
  win_t                   win_now;
  logic                   raw_hit, hit, report;
  result_t                res;
  result_t                out_res;
  logic                   push;
  logic                   skid_full;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      care_q <= '1;
      plen_q <= LEN_W'(1);
      rall_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAT_LO:     pat_q[0*CFG_W +: CFG_W] <= cfg_wdata_i;
        CFG_PAT_MID_LO: pat_q[1*CFG_W +: CFG_W] <= cfg_wdata_i;
        CFG_PAT_MID_HI: pat_q[2*CFG_W +: CFG_W] <= cfg_wdata_i;
        CFG_PAT_HI:     pat_q[3*CFG_W +: CFG_W] <= cfg_wdata_i;
        CFG_CARE_MASK:  care_q <= cfg_wdata_i[REG_BYTES-1:0];
        CFG_PAT_LEN:    plen_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_REPORT_ALL: rall_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Length zero acts as one, anything past the cap acts as the cap
  always_comb begin
    if (plen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_q > LEN_W'(LEN_CAP)) begin
      len_eff = LEN_W'(LEN_CAP);
    end else begin
      len_eff = plen_q;
    end
  end

  assign accept = in_valid_i && !in_stall_o;

  // Window after this byte shifts in
  always_comb begin
    win_now[0] = data_byte_i;
    for (int j = 1; j < int'(LEN_CAP); j++) begin
      win_now[j] = win_q[j-1];
    end
  end

  mbps_match u_match (
    .win_i       (win_now),
    .pattern_i   (pat_q),
    .care_mask_i (care_q),
    .len_i       (len_eff),
    .hit_o       (raw_hit)
  );

  // Match qualification, offsets and region bookkeeping
  always_comb begin
    fill_inc = (fill_q < FILL_W'(LEN_CAP)) ? fill_q + FILL_W'(1) : fill_q;
    hit      = raw_hit && (CMP_W'(fill_inc) >= CMP_W'(len_eff));
    report   = hit && (rall_q || !found_q);
    start    = off_q - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);

    res.match_offset = report ? MOFF_W'(start) : '0;
    res.matched      = report;
    res.region_done  = region_end_i;
    res.any_found    = region_end_i && (found_q || hit);

    push = accept && (report || region_end_i);

    if (region_end_i) begin
      fill_d  = '0;
      off_d   = '0;
      found_d = 1'b0;
    end else begin
      fill_d  = fill_inc;
      off_d   = off_q + OFFSET_BITS'(1);
      found_d = found_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      off_q   <= '0;
      found_q <= 1'b0;
      for (int j = 0; j < int'(LEN_CAP) - 1; j++) begin
        win_q[j] <= '0;
      end
    end else if (accept) begin
      fill_q  <= fill_d;
      off_q   <= off_d;
      found_q <= found_d;
      for (int j = 0; j < int'(LEN_CAP) - 1; j++) begin
        win_q[j] <= win_now[j];
      end
    end
  end

  mbps_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign in_stall_o     = skid_full;
  assign match_offset_o = out_res.match_offset;
  assign matched_o      = out_res.matched;
  assign region_done_o  = out_res.region_done;
  assign any_found_o    = out_res.any_found;

endmodule

`default_nettype wire

// ----- rtl/core/mbps_sva.sv -----
// Port-level assertions for the masked byte pattern scanner, bound to its top level.
// Depends on mbps_pkg and masked_byte_pattern_scanner_top.
`default_nettype none

module mbps_sva (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [mbps_pkg::MOFF_W-1:0]    match_offset_o,
  input  logic                           matched_o,
  input  logic                           region_done_o,
  input  logic                           any_found_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(match_offset_o) && $stable(matched_o)
      && $stable(region_done_o) && $stable(any_found_o))
    else $error("stalled result changed");

  // Every result carries a match or a region end
  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> matched_o || region_done_o)
    else $error("result with neither match nor region end");

  // Offset is zero without a match, and any_found only comes with region end
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (matched_o || match_offset_o == '0) && (region_done_o || !any_found_o))
    else $error("inconsistent result fields");

  // The input side never stalls while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind masked_byte_pattern_scanner_top mbps_sva u_mbps_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .match_offset_o (match_offset_o),
  .matched_o      (matched_o),
  .region_done_o  (region_done_o),
  .any_found_o    (any_found_o)
);

`default_nettype wire

// ----- bench/mbps_scan_checker.sv -----
// Checker for the masked byte pattern scanner: tracks the configuration
// writes and the window state, predicts scan reports and compares them.
// Depends on mbps_pkg for the register indexes and the result layout.

module mbps_scan_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mbps_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           region_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [mbps_pkg::MOFF_W-1:0]    match_offset_i,
  input  logic                           matched_i,
  input  logic                           region_done_i,
  input  logic                           any_found_i,
  output int                             mismatch_count_o,
  output int                             reports_pending_o
);

  // Shadow of the configuration registers
  logic [7:0]  sig_bytes [32];
  logic [31:0] care_bits;
  logic [5:0]  sig_len;
  logic        report_every;

  // Shadow of the scan state
  logic [7:0]  recent_bytes [32];
  int unsigned bytes_held;
  logic [31:0] next_offset;
  logic        region_hit;

  mbps_pkg::result_t scan_reports_q [$];

  // Shift one byte into the window and queue the report it causes, if any
  task automatic scan_byte(input logic [7:0] b, input logic last);
    int unsigned       span;
    logic              hit;
    logic              report;
    logic [31:0]       start;
    mbps_pkg::result_t rep;
    span = sig_len;
    if (span == 0) span = 1;
    if (span > 32) span = 32;
    for (int k = 31; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = b;
    if (bytes_held < 32) bytes_held++;
    hit = 1'b0;
    if (bytes_held >= span) begin
      hit = 1'b1;
      for (int k = 0; k < span; k++) begin
        if (care_bits[k] && sig_bytes[k] != recent_bytes[span-1-k]) hit = 1'b0;
      end
    end
    report = 1'b0;
    start  = '0;
    if (hit) begin
      report     = report_every || !region_hit;
      region_hit = 1'b1;
      start      = next_offset - 32'(span - 1);
    end
    next_offset = next_offset + 32'd1;
    if (report || last) begin
      rep.match_offset = report ? start : '0;
      rep.matched      = report;
      rep.region_done  = last;
      rep.any_found    = last && region_hit;
      scan_reports_q   = {scan_reports_q, rep};
    end
    if (last) begin
      bytes_held  = 0;
      next_offset = '0;
      region_hit  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mbps_pkg::result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 32; k++) begin
        sig_bytes[k]    = '0;
        recent_bytes[k] = '0;
      end
      care_bits        = '1;
      sig_len          = 6'd1;
      report_every     = 1'b1;
      bytes_held       = 0;
      next_offset      = '0;
      region_hit       = 1'b0;
      mismatch_count_o = 0;
      scan_reports_q.delete();
    end else begin
      // byte transfer, seen with the registers as they were before this edge
      if (in_valid_i && !in_stall_i) scan_byte(data_byte_i, region_end_i);
      // configuration write
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mbps_pkg::CFG_PAT_LO, mbps_pkg::CFG_PAT_MID_LO,
          mbps_pkg::CFG_PAT_MID_HI, mbps_pkg::CFG_PAT_HI: begin
            for (int j = 0; j < 8; j++) sig_bytes[8*cfg_idx_i + j] = cfg_wdata_i[8*j +: 8];
          end
          mbps_pkg::CFG_CARE_MASK:  care_bits    = cfg_wdata_i[31:0];
          mbps_pkg::CFG_PAT_LEN:    sig_len      = cfg_wdata_i[5:0];
          mbps_pkg::CFG_REPORT_ALL: report_every = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // result transfer
      if (out_valid_i && !out_stall_i) begin
        if (scan_reports_q.size() == 0) begin
          $error("unexpected result: offset %0h matched %0b done %0b found %0b",
                 match_offset_i, matched_i, region_done_i, any_found_i);
          mismatch_count_o++;
        end else begin
          want = scan_reports_q.pop_front();
          if (match_offset_i !== want.match_offset) begin
            $error("match_offset: expected %0h, got %0h", want.match_offset, match_offset_i);
            mismatch_count_o++;
          end
          if (matched_i !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, matched_i);
            mismatch_count_o++;
          end
          if (region_done_i !== want.region_done) begin
            $error("region_done: expected %0b, got %0b", want.region_done, region_done_i);
            mismatch_count_o++;
          end
          if (any_found_i !== want.any_found) begin
            $error("any_found: expected %0b, got %0b", want.any_found, any_found_i);
            mismatch_count_o++;
          end
        end
      end
    end
    reports_pending_o = scan_reports_q.size();
  end

endmodule

// ----- bench/masked_byte_pattern_scanner_top_test.sv -----
// Testbench top for the masked byte pattern scanner: clock, reset, byte and
// configuration stimulus, consumer stalls and the verdict.
// Depends on mbps_pkg, masked_byte_pattern_scanner_top and mbps_scan_checker.

module masked_byte_pattern_scanner_top_test;

  localparam int unsigned BYTE_TARGET = 530;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_idx = mbps_pkg::CFG_PAT_LO;
  logic [mbps_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     data_byte = '0;
  logic                           region_end = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mbps_pkg::MOFF_W-1:0]    match_offset;
  logic                           matched;
  logic                           region_done;
  logic                           any_found;

  int          mismatches;
  int          reports_pending;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  // Stimulus copy of the configured signature
  logic [7:0]  sig_b [32];
  logic [31:0] care_v;
  logic [5:0]  len_v;
  logic        all_v;
  logic [7:0]  region_buf [128];

  masked_byte_pattern_scanner_top u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .data_byte_i   (data_byte),
    .region_end_i  (region_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .match_offset_o(match_offset),
    .matched_o     (matched),
    .region_done_o (region_done),
    .any_found_o   (any_found)
  );

  mbps_scan_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .region_end_i     (region_end),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .match_offset_i   (match_offset),
    .matched_i        (matched),
    .region_done_i    (region_done),
    .any_found_i      (any_found),
    .mismatch_count_o (mismatches),
    .reports_pending_o(reports_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("masked_byte_pattern_scanner_top verification failed");
      $finish;
    end
  end

  // Consumer stall: modes change after runs of random length, one of them never stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cycle_count % 8) < 3);
    endcase
  end

  // One byte transfer; bursts of random length separated by random gaps
  task automatic put_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= b;
    region_end <= last;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop sending and wait until every report has been taken
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input mbps_pkg::cfg_idx_e idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Write every register from the stimulus copy
  task automatic load_config;
    logic [63:0] word;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 8; j++) word[8*j +: 8] = sig_b[8*r + j];
      write_reg(mbps_pkg::cfg_idx_e'(r), word);
    end
    write_reg(mbps_pkg::CFG_CARE_MASK, {32'h0, care_v});
    write_reg(mbps_pkg::CFG_PAT_LEN, {58'h0, len_v});
    write_reg(mbps_pkg::CFG_REPORT_ALL, {63'h0, all_v});
  endtask

  task automatic send_region(input int unsigned n, input logic close);
    for (int i = 0; i < n; i++) put_byte(region_buf[i], close && (i == n - 1));
  endtask

  function automatic int unsigned span_of(input logic [5:0] l);
    if (l == 0) return 1;
    if (l > 32) return 32;
    return l;
  endfunction

  // Random configuration; the first phases pin the extremes
  task automatic pick_config(input int unsigned phase);
    int unsigned style;
    int unsigned fill;
    style = $urandom_range(0, 3);
    fill  = $urandom_range(0, 255);
    for (int k = 0; k < 32; k++) begin
      case (style)
        0:       sig_b[k] = 8'($urandom_range(0, 255));
        1:       sig_b[k] = 8'h00;
        2:       sig_b[k] = 8'hFF;
        default: sig_b[k] = fill[7:0];
      endcase
    end
    case ($urandom_range(0, 5))
      0, 1, 2: care_v = '1;
      3:       care_v = $urandom;
      4:       care_v = $urandom & $urandom;
      default: care_v = '0;
    endcase
    case ($urandom_range(0, 7))
      0:       len_v = 6'd0;
      1:       len_v = 6'd32;
      2:       len_v = 6'($urandom_range(33, 63));
      3:       len_v = 6'($urandom_range(9, 31));
      default: len_v = 6'($urandom_range(1, 8));
    endcase
    all_v = 1'($urandom_range(0, 1));
    case (phase)
      0: begin
        len_v  = 6'd63;
        care_v = '0;
        all_v  = 1'b1;
      end
      1: begin
        for (int k = 0; k < 32; k++) sig_b[k] = 8'hFF;
        len_v  = 6'd32;
        care_v = '1;
      end
      2: begin
        for (int k = 0; k < 32; k++) sig_b[k] = 8'h00;
        len_v  = 6'd1;
        all_v  = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Random region with the signature planted at up to three spots
  task automatic make_region(output int unsigned n);
    int unsigned span;
    int unsigned at;
    int unsigned near;
    span = span_of(len_v);
    if (span > 12 && $urandom_range(0, 3) != 0)
      n = $urandom_range((span > 3) ? span - 3 : 1, span + 12);
    else
      n = $urandom_range(1, 24);
    near = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      if (near && $urandom_range(0, 1))
        region_buf[i] = sig_b[$urandom_range(0, span - 1)];
      else
        region_buf[i] = 8'($urandom_range(0, 255));
    end
    if (n >= span) begin
      repeat ($urandom_range(0, 3)) begin
        at = $urandom_range(0, n - span);
        for (int k = 0; k < span; k++)
          if (care_v[k]) region_buf[at + k] = sig_b[k];
      end
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: one-byte signature 00, all bytes significant
    region_buf[0] = 8'h00;
    region_buf[1] = 8'hFF;
    region_buf[2] = 8'h00;
    send_region(3, 1'b1);
    drain();

    // Three-byte signature with a wildcard in the middle
    for (int k = 0; k < 32; k++) sig_b[k] = 8'h00;
    sig_b[0] = 8'hA5;
    sig_b[1] = 8'h5A;
    sig_b[2] = 8'hC3;
    care_v   = 32'hFFFF_FFFD;
    len_v    = 6'd3;
    all_v    = 1'b1;
    load_config();
    region_buf[0] = 8'hA5;
    region_buf[1] = 8'h00;
    region_buf[2] = 8'hC3;
    region_buf[3] = 8'hA5;
    region_buf[4] = 8'hFF;
    region_buf[5] = 8'hC3;
    send_region(6, 1'b1);
    drain();

    // First-match mode on the same region, then a region shorter than the signature
    write_reg(mbps_pkg::CFG_REPORT_ALL, 64'h0);
    send_region(6, 1'b1);
    region_buf[0] = 8'hA5;
    region_buf[1] = 8'hC3;
    send_region(2, 1'b1);
    drain();

    // Zero length behaves as one byte; back-to-back matches
    write_reg(mbps_pkg::CFG_PAT_LEN, 64'h0);
    write_reg(mbps_pkg::CFG_REPORT_ALL, 64'h1);
    region_buf[0] = 8'hA5;
    region_buf[1] = 8'hA5;
    send_region(2, 1'b1);
    drain();

    // Random phases; an occasional missing region end merges two regions
    phase = 0;
    while (bytes_sent < BYTE_TARGET) begin
      pick_config(phase);
      load_config();
      repeat ($urandom_range(2, 6)) begin
        make_region(n);
        send_region(n, $urandom_range(0, 5) != 0);
      end
      drain();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("masked_byte_pattern_scanner_top verification clean");
    end else begin
      $display("masked_byte_pattern_scanner_top verification failed");
    end
    $finish;
  end

endmodule
